// ----- hdl/tfst_pkg.sv -----
// Shared types, constants and helpers of the touch frame slot tracker.
// Used by the front, queue, back, top level and checker; no dependencies.

package tfst_pkg;

    localparam int SLOTS      = 10;
    localparam int ID_W       = 5;
    localparam int COORD_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int CNT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CFG_IDX_W  = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [COORD_W-1:0] X_LIMIT_RST = 12'd1024;
    localparam logic [COORD_W-1:0] Y_LIMIT_RST = 12'd768;
    localparam logic [BYTE_W-1:0]  EMPTY_BYTE  = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 4'd1;

    localparam logic [2:0] ST_DOWN = 3'd1;
    localparam logic [2:0] ST_MOVE = 3'd2;

    typedef enum logic [1:0] {
        KIND_CONTACT = 2'd0,
        KIND_LIFT    = 2'd1,
        KIND_SYNC    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_LIFT,
        BS_SYNC
    } t_bstate;

    // one classified record handed from front to back
    typedef struct packed {
        logic                contact;
        logic                frame_end;
        logic [ID_W-1:0]     slot;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [BYTE_W-1:0]   pressure;
    } t_cmd;

    // queue handshake towards the front
    typedef struct packed {
        logic push;
        logic full;
    } t_qwr;

    // lowest pressed slot of a mask; zero when the mask is empty
    function automatic logic [ID_W-1:0] lowest_set(input logic [SLOTS-1:0] m);
        logic [ID_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (m[i]) idx = ID_W'(i);
        end
        return idx;
    endfunction

endpackage

// ----- hdl/tfst_front.sv -----
// Front end: holds the coordinate limits and the record counter, unpacks
// each record and classifies it. Depends on tfst_pkg.

module tfst_front import tfst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_W-1:0]    i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_DATA_W-1:0]  i_data,
    output t_qwr                  o_qwr_push,
    input  logic                  i_q_full,
    output t_cmd                  o_cmd
);

    logic [COORD_W-1:0] r_x_limit, n_x_limit;
    logic [COORD_W-1:0] r_y_limit, n_y_limit;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic [BYTE_W-1:0]  x_high, y_high, nibbles, status_id, pressure;
    logic [2:0]         status;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x, y;
    logic               accept, contact, frame_end;

    assign x_high    = i_data[7:0];
    assign y_high    = i_data[15:8];
    assign nibbles   = i_data[23:16];
    assign status_id = i_data[31:24];
    assign pressure  = i_data[39:32];

    assign status = status_id[2:0];
    assign id     = status_id[7:3];
    assign x      = {x_high, nibbles[7:4]};
    assign y      = {y_high, nibbles[3:0]};

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign contact = (x_high != EMPTY_BYTE) && (y_high != EMPTY_BYTE)
                  && ((status == ST_DOWN) || (status == ST_MOVE))
                  && (x <= r_x_limit) && (y <= r_y_limit)
                  && (id != '0) && (id <= ID_W'(SLOTS));

    assign frame_end = (r_cnt == CNT_W'(SLOTS - 1));

    // records that neither touch nor close a frame have nothing to do
    assign o_qwr_push.push = accept && (contact || frame_end);
    assign o_qwr_push.full = i_q_full;

    always_comb begin
        o_cmd.contact   = contact;
        o_cmd.frame_end = frame_end;
        o_cmd.slot      = id - ID_W'(1);
        o_cmd.x         = x;
        o_cmd.y         = y;
        o_cmd.pressure  = pressure;
    end

    always_comb begin
        n_x_limit = r_x_limit;
        n_y_limit = r_y_limit;
        n_cnt     = r_cnt;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_LIMIT: n_x_limit = i_cfg_data;
                CFG_Y_LIMIT: n_y_limit = i_cfg_data;
                default:     ;
            endcase
        end
        if (accept) begin
            n_cnt = frame_end ? '0 : r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= X_LIMIT_RST;
            r_y_limit <= Y_LIMIT_RST;
            r_cnt     <= '0;
        end else begin
            r_x_limit <= n_x_limit;
            r_y_limit <= n_y_limit;
            r_cnt     <= n_cnt;
        end
    end

endmodule

// ----- hdl/tfst_queue.sv -----
// Short command queue between front and back end.
// Depends on tfst_pkg for the command type and depth.

module tfst_queue import tfst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qwr  i_qwr,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_cmd  o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push, pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_qwr.push && !i_qwr.full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
            end
            if (push && !pop)      r_count <= r_count + Q_CNT_W'(1);
            else if (pop && !push) r_count <= r_count - Q_CNT_W'(1);
        end
    end

endmodule

// ----- hdl/tfst_back.sv -----
// Back end: slot masks, event emission and the output register.
// Depends on tfst_pkg.

module tfst_back import tfst_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_DATA_W-1:0]  o_data,
    output logic [1:0]             o_user,
    output logic                   o_last
);

    t_bstate            r_state, n_state;
    logic [SLOTS-1:0]   r_cur, n_cur;
    logic [SLOTS-1:0]   r_prev, n_prev;
    logic [SLOTS-1:0]   r_lift, n_lift;
    logic               r_ev, n_ev;
    logic               r_valid, n_valid;
    t_kind              r_kind, n_kind;
    logic [ID_W-1:0]    r_slot, n_slot;
    logic [COORD_W-1:0] r_x, n_x, r_y, n_y;
    logic [BYTE_W-1:0]  r_pr, n_pr;
    logic               r_last, n_last;

    logic               can_load;
    logic [SLOTS-1:0]   hit, cur_new, lifted;
    logic [ID_W-1:0]    lift_idx;

    assign can_load = !r_valid || i_ready;
    assign hit      = i_cmd.contact ? (SLOTS'(1) << i_cmd.slot) : '0;
    assign cur_new  = r_cur | hit;
    assign lifted   = r_prev & ~cur_new;
    assign lift_idx = lowest_set(r_lift);

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_lift  = r_lift;
        n_ev    = r_ev;
        n_valid = r_valid && !i_ready;
        n_kind  = r_kind;
        n_slot  = r_slot;
        n_x     = r_x;
        n_y     = r_y;
        n_pr    = r_pr;
        n_last  = r_last;
        o_pop   = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid && can_load) begin
                    o_pop = 1'b1;
                    if (i_cmd.contact) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_CONTACT;
                        n_slot  = i_cmd.slot;
                        n_x     = i_cmd.x;
                        n_y     = i_cmd.y;
                        n_pr    = i_cmd.pressure;
                        // a contact closing a frame is always followed by sync
                        n_last  = !i_cmd.frame_end;
                    end
                    if (i_cmd.frame_end) begin
                        n_prev = cur_new;
                        n_cur  = '0;
                        n_ev   = 1'b0;
                        n_lift = lifted;
                        if (lifted != '0)                      n_state = BS_LIFT;
                        else if (r_ev || i_cmd.contact)        n_state = BS_SYNC;
                    end else begin
                        n_cur = cur_new;
                        n_ev  = r_ev || i_cmd.contact;
                    end
                end
            end
            BS_LIFT: begin
                if (can_load) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_LIFT;
                    n_slot  = lift_idx;
                    n_x     = '0;
                    n_y     = '0;
                    n_pr    = '0;
                    n_last  = 1'b0;
                    n_lift  = r_lift & ~(SLOTS'(1) << lift_idx);
                    if (n_lift == '0) n_state = BS_SYNC;
                end
            end
            BS_SYNC: begin
                if (can_load) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_SYNC;
                    n_slot  = '0;
                    n_x     = '0;
                    n_y     = '0;
                    n_pr    = '0;
                    n_last  = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_cur   <= '0;
            r_prev  <= '0;
            r_lift  <= '0;
            r_ev    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_lift  <= n_lift;
            r_ev    <= n_ev;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_slot <= n_slot;
        r_x    <= n_x;
        r_y    <= n_y;
        r_pr   <= n_pr;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_user  = r_kind;
    assign o_last  = r_last;
    assign o_data  = {{(OUT_DATA_W - SLOT_OUT_W - 2 * COORD_W - BYTE_W){1'b0}},
                      r_pr, r_y, r_x, r_slot[SLOT_OUT_W-1:0]};

endmodule

// ----- hdl/touch_frame_slot_tracker.sv -----
// Touch frame slot tracker, top level: front end, command queue, back end.
// Depends on tfst_pkg, tfst_front, tfst_queue and tfst_back.
//
// Input stream: one raw finger record per beat; a frame is SLOTS records.
// Output stream: contact, lift and sync events; tlast marks the final event
// caused by one record, tuser carries the event kind.
// Configuration: i_cfg_valid/o_cfg_ready write channel, index 0 is x_limit,
// index 1 is y_limit; other indexes are ignored. Always ready; write only
// while the block is idle.
// Path: a contact record is written into the queue, then the back end pops it
// into the output register that drives the output stream.
// Throughput: a record is taken each cycle while the two-entry queue has
// room; the back end emits one event per cycle while the receiver is ready,
// so a frame-closing record holds it for its contact, lifts and sync. Records
// that neither touch nor close a frame pass the front end only.
// Reset: masks, counter and queue cleared, limits back to 1024 and 768.
// Receiver stall: the output register holds its beat; the queue absorbs up
// to two records, then s_axis_tready falls.

module touch_frame_slot_tracker import tfst_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_W-1:0]     i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // x_high[7:0], y_high[15:8], low_nibbles[23:16], status_id[31:24],
    // pressure[39:32]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // slot[3:0], pos_x[15:4], pos_y[27:16], touch_pressure[35:28], zero[39:36]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_qwr qwr;
    t_cmd front_cmd, back_cmd;
    logic q_full, q_valid, q_pop;

    assign o_cfg_ready = 1'b1;

    tfst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .o_qwr_push  (qwr),
        .i_q_full    (q_full),
        .o_cmd       (front_cmd)
    );

    tfst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (back_cmd)
    );

    tfst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (back_cmd),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

// ----- hdl/tfst_checker.sv -----
// Port-level checks on the tracker output stream, bound to the top level.
// Depends on tfst_pkg and touch_frame_slot_tracker.

module tfst_checker import tfst_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // sync always closes a record's events
    a_sync_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SYNC) |-> m_axis_tlast)
        else $error("sync without tlast");

    // a lift is never marked last, since a sync always follows it
    a_lift_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_LIFT) |-> !m_axis_tlast)
        else $error("lift marked last");

    // only contacts carry coordinates and pressure
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_CONTACT)
            |-> (m_axis_tdata[OUT_DATA_W-1:SLOT_OUT_W] == '0))
        else $error("lift or sync with payload");

    // sync carries slot zero
    a_sync_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SYNC)
            |-> (m_axis_tdata[SLOT_OUT_W-1:0] == '0))
        else $error("sync with non-zero slot");

endmodule

bind touch_frame_slot_tracker tfst_checker u_tfst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/touch_frame_slot_tracker_test.sv -----
// Self-checking testbench of touch_frame_slot_tracker: queued record and register
// traffic, a frame tracker that predicts contact, lift and sync events, and a checker.
// Depends on tfst_pkg and the touch_frame_slot_tracker RTL only.

module touch_frame_slot_tracker_test import tfst_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = SLOTS + 10;
    localparam int GAP_MAX       = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'hF;
    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_UP   = 3'd3;
    localparam logic [2:0] ST_RSVD = 3'd7;

    // x_high lowest, pressure highest, as on s_axis_tdata
    typedef struct packed {
        logic [7:0] pressure;
        logic [7:0] status_id;
        logic [7:0] low_nibbles;
        logic [7:0] y_high;
        logic [7:0] x_high;
    } t_record;

    typedef struct packed {
        t_kind               kind;
        logic [3:0]          slot;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [7:0]          pressure;
        logic                last;
    } t_event;

    typedef enum {JOB_RECORD, JOB_CFG_WRITE, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind           kind;
        t_record             rec;
        logic [CFG_IDX_W-1:0] idx;
        logic [COORD_W-1:0]  val;
        int unsigned         gap;
    } t_job;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COORD_W-1:0]    i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    touch_frame_slot_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    t_job        jobs[$];
    t_event      events_due[$];
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int unsigned hold_cycles = 0;
    int unsigned stall_left = 0;
    logic        rec_fired = 1'b0;
    logic        cfg_fired = 1'b0;
    logic        ev_fired = 1'b0;
    logic        rx_calm = 1'b0;
    logic        calm = 1'b0;
    logic [SLOTS-1:0] fingers = '0;

    // frame tracker state
    logic [COORD_W-1:0] lim_x = X_LIMIT_RST;
    logic [COORD_W-1:0] lim_y = Y_LIMIT_RST;
    logic [SLOTS-1:0]   pressed_now = '0;
    logic [SLOTS-1:0]   pressed_before = '0;
    int                 frame_pos = 0;
    logic               frame_active = 1'b0;

    task automatic report_mismatch(input string what);
        if (err_cnt < 40) $display("[%0t] mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    task automatic track_record(input t_record r);
        logic [2:0]         status;
        logic [4:0]         id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SLOTS-1:0]   lifted;
        t_event             e;
        int                 n;
        status = r.status_id[2:0];
        id     = r.status_id[7:3];
        x      = {r.x_high, r.low_nibbles[7:4]};
        y      = {r.y_high, r.low_nibbles[3:0]};
        n      = 0;
        if (r.x_high != EMPTY_BYTE && r.y_high != EMPTY_BYTE &&
            (status == ST_DOWN || status == ST_MOVE) && x <= lim_x && y <= lim_y &&
            id >= 1 && id <= SLOTS) begin
            e = '0;
            e.kind = KIND_CONTACT;
            e.slot = 4'(id - 1);
            e.pos_x = x;
            e.pos_y = y;
            e.pressure = r.pressure;
            events_due.push_back(e);
            n++;
            frame_active = 1'b1;
            pressed_now[id - 1] = 1'b1;
        end
        frame_pos++;
        if (frame_pos >= SLOTS) begin
            lifted = pressed_before & ~pressed_now;
            for (int i = 0; i < SLOTS; i++) begin
                if (lifted[i]) begin
                    e = '0;
                    e.kind = KIND_LIFT;
                    e.slot = 4'(i);
                    events_due.push_back(e);
                    n++;
                    frame_active = 1'b1;
                end
            end
            if (frame_active) begin
                e = '0;
                e.kind = KIND_SYNC;
                events_due.push_back(e);
                n++;
            end
            pressed_before = pressed_now;
            pressed_now = '0;
            frame_active = 1'b0;
            frame_pos = 0;
        end
        if (n > 0) events_due[$].last = 1'b1;
    endtask

    // ---------------- stimulus building ----------------

    function automatic int unsigned next_gap();
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic t_record record_of(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [2:0] status, input logic [4:0] id,
                                          input logic [7:0] pr);
        t_record r;
        r.x_high = x[11:4];
        r.y_high = y[11:4];
        r.low_nibbles = {x[3:0], y[3:0]};
        r.status_id = {id, status};
        r.pressure = pr;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int lim);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return COORD_W'($urandom_range(0, 4095));
        if (roll == 1) return COORD_W'(lim);
        return COORD_W'($urandom_range(0, lim));
    endfunction

    task automatic push_record(input t_record r);
        t_job j;
        j.kind = JOB_RECORD;
        j.rec = r;
        j.idx = '0;
        j.val = '0;
        j.gap = next_gap();
        jobs.push_back(j);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        t_job j;
        j.kind = JOB_CFG_WRITE;
        j.rec = '0;
        j.idx = idx;
        j.val = val;
        j.gap = next_gap();
        jobs.push_back(j);
    endtask

    task automatic push_drain();
        t_job j;
        j.kind = JOB_DRAIN;
        j.rec = '0;
        j.idx = '0;
        j.val = '0;
        j.gap = 0;
        jobs.push_back(j);
    endtask

    // random bytes with the empty marker in one or both coordinate bytes
    function automatic t_record blank_record();
        t_record r;
        r = t_record'({$urandom(), 8'($urandom())});
        case ($urandom_range(0, 5))
            0: r.x_high = EMPTY_BYTE;
            1: r.y_high = EMPTY_BYTE;
            default: begin
                r.x_high = EMPTY_BYTE;
                r.y_high = EMPTY_BYTE;
            end
        endcase
        return r;
    endfunction

    // fingers persist from frame to frame, so lifts are partial and sporadic
    task automatic well_frame(input int lx, input int ly);
        int         roll;
        logic [2:0] st;
        logic [4:0] id;
        for (int i = 0; i < SLOTS; i++)
            if ($urandom_range(0, 3) == 0) fingers[i] = ~fingers[i];
        for (int j = 0; j < SLOTS; j++) begin
            roll = $urandom_range(0, 19);
            st = ($urandom_range(0, 1) == 0) ? ST_DOWN : ST_MOVE;
            id = 5'(j + 1);
            if (fingers[j]) begin
                if (roll == 17) id = 5'($urandom_range(1, SLOTS));
                else if (roll == 18) st = 3'($urandom_range(0, 7));
                else if (roll == 19) id = 5'($urandom_range(0, 31));
                push_record(record_of(pick_coord(lx), pick_coord(ly), st, id,
                                      8'($urandom())));
            end else if (roll < 14) begin
                push_record(blank_record());
            end else if (roll < 17) begin
                push_record(record_of(pick_coord(lx), pick_coord(ly), ST_UP, id,
                                      8'($urandom())));
            end else begin
                push_record(record_of(pick_coord(lx), pick_coord(ly), st,
                                      5'($urandom_range(1, SLOTS)), 8'($urandom())));
            end
        end
    endtask

    task automatic noise_frame();
        for (int j = 0; j < SLOTS; j++)
            push_record(t_record'({$urandom(), 8'($urandom())}));
    endtask

    task automatic blank_frame();
        for (int j = 0; j < SLOTS; j++) push_record(blank_record());
    endtask

    // ---------------- sender ----------------

    always @(negedge i_clk) begin
        t_job job;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if ((s_axis_tvalid && !rec_fired) || (i_cfg_valid && !cfg_fired)) begin
            // beat still waiting for ready
        end else if (hold_cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (jobs.size() == 0) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            job = jobs[0];
            case (job.kind)
                JOB_RECORD: begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= job.rec;
                    i_cfg_valid <= 1'b0;
                    hold_cycles <= job.gap;
                    void'(jobs.pop_front());
                end
                JOB_CFG_WRITE: begin
                    s_axis_tvalid <= 1'b0;
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= job.idx;
                    i_cfg_data <= job.val;
                    hold_cycles <= job.gap;
                    void'(jobs.pop_front());
                end
                JOB_DRAIN: begin
                    s_axis_tvalid <= 1'b0;
                    i_cfg_valid <= 1'b0;
                    // a quiet frame end may still be in the back end
                    if (events_due.size() == 0) begin
                        hold_cycles <= SETTLE_CYCLES;
                        void'(jobs.pop_front());
                    end
                end
            endcase
        end
    end

    // ---------------- receiver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (ev_fired) begin
                if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- monitor and checker ----------------

    always @(posedge i_clk) begin
        t_event got;
        t_event want;
        rec_fired <= s_axis_tvalid && s_axis_tready;
        cfg_fired <= i_cfg_valid && o_cfg_ready;
        ev_fired <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_LIMIT: lim_x = i_cfg_data;
                    CFG_Y_LIMIT: lim_y = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) track_record(t_record'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = t_kind'(m_axis_tuser);
                got.slot = m_axis_tdata[3:0];
                got.pos_x = m_axis_tdata[15:4];
                got.pos_y = m_axis_tdata[27:16];
                got.pressure = m_axis_tdata[35:28];
                got.last = m_axis_tlast;
                if (events_due.size() == 0) begin
                    report_mismatch($sformatf("event kind %0d slot %0d with none pending",
                                              got.kind, got.slot));
                end else begin
                    want = events_due.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
                    if (got.pos_x !== want.pos_x)
                        report_mismatch($sformatf("pos_x %0d, want %0d",
                                                  got.pos_x, want.pos_x));
                    if (got.pos_y !== want.pos_y)
                        report_mismatch($sformatf("pos_y %0d, want %0d",
                                                  got.pos_y, want.pos_y));
                    if (got.pressure !== want.pressure)
                        report_mismatch($sformatf("pressure %0d, want %0d",
                                                  got.pressure, want.pressure));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("tlast %0b, want %0b", got.last, want.last));
                    if (m_axis_tdata[OUT_DATA_W-1:36] !== '0)
                        report_mismatch("tdata padding not zero");
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial begin
        int lim_tab_x[5] = '{1024, 4095, 0, 4095, 0};
        int lim_tab_y[5] = '{768, 4095, 0, 0, 0};

        // frame one: valid contacts at the extremes, a repeated id, empty bytes, bad status, bad id
        calm = 1'b0;
        push_record(record_of(12'd0, 12'd0, ST_DOWN, 5'd1, 8'd0));
        push_record(record_of(12'd1024, 12'd768, ST_MOVE, 5'(SLOTS), 8'd255));
        push_record(record_of(12'd100, 12'd200, ST_DOWN, 5'd5, 8'd77));
        push_record(record_of(12'd101, 12'd201, ST_MOVE, 5'd5, 8'd78));
        push_record(record_of(12'hFF3, 12'd50, ST_DOWN, 5'd2, 8'd9));
        push_record(record_of(12'd50, 12'hFF3, ST_DOWN, 5'd3, 8'd9));
        push_record(record_of(12'd60, 12'd60, ST_UP, 5'd2, 8'd10));
        push_record(record_of(12'd61, 12'd61, ST_NONE, 5'd3, 8'd11));
        push_record(record_of(12'd62, 12'd62, ST_DOWN, 5'd0, 8'd12));
        push_record(record_of(12'd63, 12'd63, ST_MOVE, 5'd31, 8'd13));
        // frame two: limits overstepped by one, id past the slot count, back-to-back
        calm = 1'b1;
        push_record(record_of(12'd5, 12'd6, ST_MOVE, 5'd1, 8'd1));
        push_record(record_of(12'd1025, 12'd10, ST_DOWN, 5'd4, 8'd2));
        push_record(record_of(12'd10, 12'd769, ST_DOWN, 5'd6, 8'd3));
        push_record(record_of(12'd20, 12'd20, ST_DOWN, 5'(SLOTS + 1), 8'd4));
        push_record(record_of(12'd21, 12'd21, ST_RSVD, 5'd7, 8'd5));
        push_record(record_of(12'd22, 12'd22, 3'($urandom_range(4, 6)), 5'd8, 8'd6));
        push_record(record_of(12'd23, 12'd23, 3'($urandom_range(4, 6)), 5'd9, 8'd7));
        push_record(record_of(12'd24, 12'd24, ST_UP, 5'd3, 8'd8));
        push_record(record_of(12'hFFF, 12'hFFF, ST_DOWN, 5'd2, 8'd9));
        push_record(record_of(12'd1024, 12'd0, ST_DOWN, 5'd3, 8'd10));

        lim_tab_x[4] = $urandom_range(0, 4095);
        lim_tab_y[4] = $urandom_range(0, 4095);
        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                push_drain();
                push_cfg(CFG_X_LIMIT, COORD_W'(lim_tab_x[p]));
                push_cfg(CFG_Y_LIMIT, COORD_W'(lim_tab_y[p]));
                if (p == 3) push_cfg(CFG_UNUSED, COORD_W'($urandom()));
            end
            calm = ($urandom_range(0, 3) == 0);
            well_frame(lim_tab_x[p], lim_tab_y[p]);
            calm = ($urandom_range(0, 3) == 0);
            noise_frame();
            calm = ($urandom_range(0, 3) == 0);
            well_frame(lim_tab_x[p], lim_tab_y[p]);
            calm = ($urandom_range(0, 3) == 0);
            well_frame(lim_tab_x[p], lim_tab_y[p]);
            calm = ($urandom_range(0, 3) == 0);
            blank_frame();
            if (p == 0) begin
                // second empty frame closes with no event at all
                blank_frame();
                push_drain();
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs.size() != 0 || s_axis_tvalid || i_cfg_valid) @(posedge i_clk);
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
